// ===== rtl/abp_pkg.sv =====
// ----------------------------------------------------------------------------
// abp_pkg
// Constants, types and tables for the active Brownian particle step.
// ----------------------------------------------------------------------------
package abp_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ATAN_ENTRIES      = 30;
   localparam int PIPE_DEPTH        = 2 * CORDIC_ITERATIONS + 3;
   localparam int SIDE_FIRST        = 4;
   localparam int SIDE_LAST         = 2 * CORDIC_ITERATIONS + 2;
   localparam int STEP_TAP          = CORDIC_ITERATIONS + 1;

   localparam int VEC_W = 20;
   localparam int ROT_W = 34;
   localparam int SUM_W = 52;

   localparam logic [31:0] INV_CORDIC_GAIN = 32'd652032874;
   localparam logic [29:0] TURN_PER_RAD    = 30'd683565276;
   localparam logic [31:0] HALF_TURN       = 32'h8000_0000;

   typedef enum logic [2:0] {
      CSR_DRIFT_GAIN       = 3'd0,
      CSR_FORCE_GAIN       = 3'd1,
      CSR_TRANS_NOISE_GAIN = 3'd2,
      CSR_ROT_NOISE_GAIN   = 3'd3,
      CSR_INV_DT           = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic               grp;
      logic [31:0]        step;
   } side_type;

   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] r;
      case (idx)
         0:  r = 32'd536870912;
         1:  r = 32'd316933406;
         2:  r = 32'd167458907;
         3:  r = 32'd85004756;
         4:  r = 32'd42667331;
         5:  r = 32'd21354465;
         6:  r = 32'd10679838;
         7:  r = 32'd5340245;
         8:  r = 32'd2670163;
         9:  r = 32'd1335087;
         10: r = 32'd667544;
         11: r = 32'd333772;
         12: r = 32'd166886;
         13: r = 32'd83443;
         14: r = 32'd41722;
         15: r = 32'd20861;
         16: r = 32'd10430;
         17: r = 32'd5215;
         18: r = 32'd2608;
         19: r = 32'd1304;
         20: r = 32'd652;
         21: r = 32'd326;
         22: r = 32'd163;
         23: r = 32'd81;
         24: r = 32'd41;
         25: r = 32'd20;
         26: r = 32'd10;
         27: r = 32'd5;
         28: r = 32'd3;
         29: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/active_brownian_particle_step.sv =====
// ----------------------------------------------------------------------------
// active_brownian_particle_step
// One Euler-Maruyama step of a 2D active Brownian particle per request.
//
//  channel  ports              handshake                   width
//  request  req_*              start & !busy               32/16/1 fields
//  result   rsp_*              rsp_valid, one cycle        32/16 fields
//  config   csr_*              csr_we, no wait             3-bit index, 32 data
//
//  A request enters every cycle; its result passes through the vectoring
//  and rotation CORDIC pipelines, one stage per iteration. busy stays low.
//  Synchronous reset clears the valid bits and loads the register defaults.
//  The receiver cannot stall; the pipeline always advances.
// ----------------------------------------------------------------------------
module active_brownian_particle_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_force_x,
   input  logic signed [31:0] req_force_y,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic signed [15:0] req_noise_x,
   input  logic signed [15:0] req_noise_y,
   input  logic signed [15:0] req_noise_rot,
   input  logic               req_in_group,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [15:0] rsp_new_dir_x,
   output logic signed [15:0] rsp_new_dir_y,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   input  logic               csr_we,
   input  abp_pkg::csr_index_type csr_index,
   input  logic [31:0]        csr_wdata
);
   import abp_pkg::*;

   localparam int N = CORDIC_ITERATIONS;

   logic [31:0] drift_gain_ff, force_gain_ff, trans_gain_ff, rot_gain_ff, inv_dt_ff;
   logic        vld_ff [1:PIPE_DEPTH];
   logic        accept;

   logic signed [31:0] s1_pos_x_ff, s1_pos_y_ff;
   logic signed [15:0] s1_dir_x_ff, s1_dir_y_ff;
   logic               s1_grp_ff;
   logic signed [48:0] s1_pd_x_ff, s1_pd_y_ff, s1_pn_x_ff, s1_pn_y_ff, s1_pr_ff;
   logic signed [64:0] s1_pf_x_ff, s1_pf_y_ff;

   logic signed [31:0] s2_q_x_ff, s2_q_y_ff, s2_pos_x_ff, s2_pos_y_ff;
   logic signed [31:0] s2_q_x_in, s2_q_y_in;
   logic signed [15:0] s2_dir_x_ff, s2_dir_y_ff;
   logic               s2_grp_ff;
   logic [61:0]        s2_pp_lo_ff, s2_pp_lo_in;
   logic [27:0]        s2_pp_hi_ff, s2_pp_hi_in;
   logic [59:0]        p60;
   logic [55:0]        pp_hi_full;
   logic signed [SUM_W-1:0] sum_x, sum_y;

   logic signed [31:0] s3_q_x_ff, s3_q_y_ff;
   logic signed [15:0] s3_dir_x_ff, s3_dir_y_ff;
   logic               s3_grp_ff;
   logic signed [65:0] s3_vp_x_ff, s3_vp_y_ff, s3_vp_x_in, s3_vp_y_in;
   logic [31:0]        s3_step_ff, s3_step_in;
   logic [59:0]        step_sum;
   logic signed [32:0] disp_x, disp_y;

   side_type side_ff [SIDE_FIRST:SIDE_LAST];
   side_type side_in;

   logic signed [VEC_W-1:0] vec_x_ff [0:N];
   logic signed [VEC_W-1:0] vec_y_ff [0:N];
   logic [31:0]             vec_z_ff [0:N];
   logic                    vec_zero_ff [0:N];
   logic signed [VEC_W-1:0] vec_x_in, vec_y_in;
   logic [31:0]             vec_z_in;

   logic signed [ROT_W-1:0] rot_x_ff [0:N];
   logic signed [ROT_W-1:0] rot_y_ff [0:N];
   logic signed [ROT_W-1:0] rot_z_ff [0:N];
   logic                    rot_neg_ff [0:N];
   logic signed [ROT_W-1:0] rot_z_in;
   logic                    rot_neg_in;
   logic [31:0]             ang;

   logic signed [15:0] out_c, out_s;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         drift_gain_ff <= '0;
         force_gain_ff <= '0;
         trans_gain_ff <= '0;
         rot_gain_ff   <= '0;
         inv_dt_ff     <= 32'd65536;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DRIFT_GAIN:       drift_gain_ff <= csr_wdata;
            CSR_FORCE_GAIN:       force_gain_ff <= csr_wdata;
            CSR_TRANS_NOISE_GAIN: trans_gain_ff <= csr_wdata;
            CSR_ROT_NOISE_GAIN:   rot_gain_ff   <= csr_wdata;
            CSR_INV_DT:           inv_dt_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= PIPE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[1] <= accept;
         for (int k = 2; k <= PIPE_DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 1: products
   always_ff @(posedge clock) begin
      s1_pos_x_ff <= req_pos_x;
      s1_pos_y_ff <= req_pos_y;
      s1_dir_x_ff <= req_dir_x;
      s1_dir_y_ff <= req_dir_y;
      s1_grp_ff   <= req_in_group;
      s1_pd_x_ff  <= $signed({1'b0, drift_gain_ff}) * req_dir_x;
      s1_pd_y_ff  <= $signed({1'b0, drift_gain_ff}) * req_dir_y;
      s1_pf_x_ff  <= $signed({1'b0, force_gain_ff}) * req_force_x;
      s1_pf_y_ff  <= $signed({1'b0, force_gain_ff}) * req_force_y;
      s1_pn_x_ff  <= $signed({1'b0, trans_gain_ff}) * req_noise_x;
      s1_pn_y_ff  <= $signed({1'b0, trans_gain_ff}) * req_noise_y;
      s1_pr_ff    <= $signed({1'b0, rot_gain_ff}) * req_noise_rot;
   end

   // stage 2: new position, angle-step partial products
   always_comb begin
      sum_x = SUM_W'(s1_pd_x_ff >>> 14) + SUM_W'(s1_pf_x_ff >>> 16)
            + SUM_W'(s1_pn_x_ff >>> 12) + SUM_W'(s1_pos_x_ff);
      sum_y = SUM_W'(s1_pd_y_ff >>> 14) + SUM_W'(s1_pf_y_ff >>> 16)
            + SUM_W'(s1_pn_y_ff >>> 12) + SUM_W'(s1_pos_y_ff);
      s2_q_x_in   = s1_grp_ff ? sat32(66'(sum_x)) : s1_pos_x_ff;
      s2_q_y_in   = s1_grp_ff ? sat32(66'(sum_y)) : s1_pos_y_ff;
      p60         = 60'(s1_pr_ff);
      s2_pp_lo_in = 62'(p60[31:0]) * 62'(TURN_PER_RAD);
      pp_hi_full  = 56'(p60[59:32]) * 56'(TURN_PER_RAD[27:0]);
      s2_pp_hi_in = pp_hi_full[27:0];
   end

   always_ff @(posedge clock) begin
      s2_q_x_ff   <= s2_q_x_in;
      s2_q_y_ff   <= s2_q_y_in;
      s2_pos_x_ff <= s1_pos_x_ff;
      s2_pos_y_ff <= s1_pos_y_ff;
      s2_dir_x_ff <= s1_dir_x_ff;
      s2_dir_y_ff <= s1_dir_y_ff;
      s2_grp_ff   <= s1_grp_ff;
      s2_pp_lo_ff <= s2_pp_lo_in;
      s2_pp_hi_ff <= s2_pp_hi_in;
   end

   // stage 3: velocity products, angle step
   always_comb begin
      disp_x     = 33'(s2_q_x_ff) - 33'(s2_pos_x_ff);
      disp_y     = 33'(s2_q_y_ff) - 33'(s2_pos_y_ff);
      s3_vp_x_in = disp_x * $signed({1'b0, inv_dt_ff});
      s3_vp_y_in = disp_y * $signed({1'b0, inv_dt_ff});
      step_sum   = s2_pp_lo_ff[59:0] + {s2_pp_hi_ff, 32'd0};
      s3_step_in = step_sum[59:28];
   end

   always_ff @(posedge clock) begin
      s3_q_x_ff   <= s2_q_x_ff;
      s3_q_y_ff   <= s2_q_y_ff;
      s3_dir_x_ff <= s2_dir_x_ff;
      s3_dir_y_ff <= s2_dir_y_ff;
      s3_grp_ff   <= s2_grp_ff;
      s3_vp_x_ff  <= s3_vp_x_in;
      s3_vp_y_ff  <= s3_vp_y_in;
      s3_step_ff  <= s3_step_in;
   end

   // stage 4: velocity saturation, then hold side data alongside the CORDIC
   always_comb begin
      side_in.pos_x = s3_q_x_ff;
      side_in.pos_y = s3_q_y_ff;
      side_in.vel_x = s3_grp_ff ? sat32(s3_vp_x_ff >>> 16) : 32'sd0;
      side_in.vel_y = s3_grp_ff ? sat32(s3_vp_y_ff >>> 16) : 32'sd0;
      side_in.dir_x = s3_dir_x_ff;
      side_in.dir_y = s3_dir_y_ff;
      side_in.grp   = s3_grp_ff;
      side_in.step  = s3_step_ff;
   end

   always_ff @(posedge clock) begin
      side_ff[SIDE_FIRST] <= side_in;
      for (int k = SIDE_FIRST + 1; k <= SIDE_LAST; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // vectoring: fold left half plane
   always_comb begin
      vec_x_in = VEC_W'(req_dir_x);
      vec_y_in = VEC_W'(req_dir_y);
      vec_z_in = '0;
      if (req_dir_x < 0) begin
         vec_x_in = -VEC_W'(req_dir_x);
         vec_y_in = -VEC_W'(req_dir_y);
         vec_z_in = HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      vec_x_ff[0]    <= vec_x_in;
      vec_y_ff[0]    <= vec_y_in;
      vec_z_ff[0]    <= vec_z_in;
      vec_zero_ff[0] <= (req_dir_x == 16'sd0) && (req_dir_y == 16'sd0);
   end

   for (genvar i = 0; i < N; i++) begin : g_vec
      always_ff @(posedge clock) begin
         vec_zero_ff[i+1] <= vec_zero_ff[i];
         if (vec_y_ff[i] > 0) begin
            vec_x_ff[i+1] <= vec_x_ff[i] + (vec_y_ff[i] >>> i);
            vec_y_ff[i+1] <= vec_y_ff[i] - (vec_x_ff[i] >>> i);
            vec_z_ff[i+1] <= vec_z_ff[i] + atan_turn(i);
         end else begin
            vec_x_ff[i+1] <= vec_x_ff[i] - (vec_y_ff[i] >>> i);
            vec_y_ff[i+1] <= vec_y_ff[i] + (vec_x_ff[i] >>> i);
            vec_z_ff[i+1] <= vec_z_ff[i] - atan_turn(i);
         end
      end
   end

   // rotation: add angle step, fold beyond a quarter turn
   always_comb begin
      ang        = (vec_zero_ff[N] ? 32'd0 : vec_z_ff[N]) + side_ff[STEP_TAP].step;
      rot_z_in   = ROT_W'($signed(ang));
      rot_neg_in = 1'b0;
      if (rot_z_in > ROT_W'(32'sh4000_0000) || rot_z_in < -ROT_W'(32'sh4000_0000)) begin
         rot_z_in   = ROT_W'($signed(ang - HALF_TURN));
         rot_neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rot_x_ff[0]   <= ROT_W'(INV_CORDIC_GAIN);
      rot_y_ff[0]   <= '0;
      rot_z_ff[0]   <= rot_z_in;
      rot_neg_ff[0] <= rot_neg_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      always_ff @(posedge clock) begin
         rot_neg_ff[i+1] <= rot_neg_ff[i];
         if (rot_z_ff[i] >= 0) begin
            rot_x_ff[i+1] <= rot_x_ff[i] - (rot_y_ff[i] >>> i);
            rot_y_ff[i+1] <= rot_y_ff[i] + (rot_x_ff[i] >>> i);
            rot_z_ff[i+1] <= rot_z_ff[i] - ROT_W'(atan_turn(i));
         end else begin
            rot_x_ff[i+1] <= rot_x_ff[i] + (rot_y_ff[i] >>> i);
            rot_y_ff[i+1] <= rot_y_ff[i] - (rot_x_ff[i] >>> i);
            rot_z_ff[i+1] <= rot_z_ff[i] + ROT_W'(atan_turn(i));
         end
      end
   end

   function automatic logic signed [15:0] to_q14(input logic signed [ROT_W-1:0] v,
                                                 input logic neg);
      logic signed [ROT_W:0] t;
      logic signed [ROT_W:0] r;
      t = (ROT_W+1)'(v) + (ROT_W+1)'(32768);
      r = t >>> 16;
      if (neg) begin
         r = -r;
      end
      if (r > (ROT_W+1)'(32767)) begin
         return 16'sh7FFF;
      end else if (r < -(ROT_W+1)'(32768)) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction

   // output registers
   always_comb begin
      out_c = to_q14(rot_x_ff[N], rot_neg_ff[N]);
      out_s = to_q14(rot_y_ff[N], rot_neg_ff[N]);
   end

   assign rsp_valid = vld_ff[PIPE_DEPTH];

   always_ff @(posedge clock) begin
      rsp_new_pos_x <= side_ff[SIDE_LAST].pos_x;
      rsp_new_pos_y <= side_ff[SIDE_LAST].pos_y;
      rsp_vel_x     <= side_ff[SIDE_LAST].vel_x;
      rsp_vel_y     <= side_ff[SIDE_LAST].vel_y;
      rsp_new_dir_x <= side_ff[SIDE_LAST].grp ? out_c : side_ff[SIDE_LAST].dir_x;
      rsp_new_dir_y <= side_ff[SIDE_LAST].grp ? out_s : side_ff[SIDE_LAST].dir_y;
   end

`ifndef ASSERT_OFF
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PIPE_DEPTH rsp_valid)
      else $error("request lost in pipeline");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, PIPE_DEPTH))
      else $error("result without request");

   a_pass_through : assert property (@(posedge clock) disable iff (reset)
      vld_ff[PIPE_DEPTH-1] && !side_ff[SIDE_LAST].grp
      |=> rsp_vel_x == 32'sd0 && rsp_vel_y == 32'sd0)
      else $error("pass-through result with velocity");
`endif

endmodule
